/* sv/pisc_pkg.sv */
// Package for the point-in-shape classifier: shape codes, fixed-point constants,
// stage beat types and the quarter-wave cosine table built at elaboration.
// No dependencies.
package pisc_pkg;

    // Coordinate format: signed, COORD_FRAC_BITS fraction bits.
    localparam int unsigned COORD_W           = 20;
    localparam int unsigned COORD_FRAC_BITS   = 16;
    localparam int unsigned COS_TABLE_ENTRIES = 256;

    localparam int unsigned COS_IDX_W = $clog2(COS_TABLE_ENTRIES);
    localparam int unsigned PHASE_W   = COS_IDX_W + 2;
    localparam int unsigned PHASE_SH  = COORD_FRAC_BITS - PHASE_W;

    localparam int unsigned SQ_W    = 2 * COORD_W;
    localparam int unsigned SUM_W   = SQ_W + 2;
    localparam int unsigned CMP_W   = COORD_W + 2;
    localparam int unsigned Q30_W   = 31;
    localparam int unsigned K009_W  = 27;
    localparam int unsigned PROD_W  = Q30_W + K009_W;
    localparam int unsigned DEPTH_SH = 60 - 2 * COORD_FRAC_BITS;
    localparam int unsigned SINE_SH  = 32 - COORD_FRAC_BITS;

    // Q30 constants, rounded to nearest.
    localparam logic [63:0] K_009    = 64'd96636764;
    localparam logic [63:0] K_QPI    = 64'd85445659;
    localparam logic [63:0] K_03     = 64'd322122547;
    localparam logic [63:0] K_013    = 64'd139586437;
    localparam logic [63:0] K_037    = 64'd397284475;
    localparam logic [63:0] K_074    = 64'd794568950;
    localparam logic [63:0] K_026    = 64'd279172874;
    localparam logic [63:0] K_HALFPI = 64'd1686629713;

    localparam logic [Q30_W-1:0] Q30_ONE = Q30_W'(64'd1 << 30);

    // Move a Q30 value to fb fraction bits, rounding half up on a right shift.
    function automatic logic [63:0] q30_shift(input logic [63:0] v, input int unsigned fb);
        logic [63:0] r;
        if (fb >= 30)
            r = v << (fb - 30);
        else
            r = (v + (64'd1 << (29 - fb))) >> (30 - fb);
        return r;
    endfunction

    localparam logic [K009_W-1:0] K009 = K009_W'(K_009);

    localparam logic [SUM_W-1:0] QW     = SUM_W'(64'd1 << (2 * COORD_FRAC_BITS - 2));
    localparam logic [SUM_W-1:0] SW     = SUM_W'(64'd1 << (2 * COORD_FRAC_BITS - 4));
    localparam logic [SUM_W-1:0] QPI_2F = SUM_W'(q30_shift(K_QPI, 2 * COORD_FRAC_BITS));

    localparam logic [COORD_FRAC_BITS-1:0] K013_F = COORD_FRAC_BITS'(q30_shift(K_013, COORD_FRAC_BITS));
    localparam logic [COORD_FRAC_BITS-1:0] K074_F = COORD_FRAC_BITS'(q30_shift(K_074, COORD_FRAC_BITS));
    localparam logic [COORD_FRAC_BITS-1:0] K037_F = COORD_FRAC_BITS'(q30_shift(K_037, COORD_FRAC_BITS));
    localparam logic [COORD_FRAC_BITS-1:0] K026_F = COORD_FRAC_BITS'(q30_shift(K_026, COORD_FRAC_BITS));

    localparam logic signed [CMP_W-1:0] ONE_C  = CMP_W'(64'd1 << COORD_FRAC_BITS);
    localparam logic signed [CMP_W-1:0] HALF_C = CMP_W'(64'd1 << (COORD_FRAC_BITS - 1));
    localparam logic signed [CMP_W-1:0] QN_C   = CMP_W'(64'd1 << (COORD_FRAC_BITS - 2));
    localparam logic signed [CMP_W-1:0] QN3_C  = CMP_W'(64'd3 << (COORD_FRAC_BITS - 2));
    localparam logic signed [CMP_W-1:0] C03_C  = CMP_W'(q30_shift(K_03, COORD_FRAC_BITS));

    typedef enum logic [4:0] {
        SHP_CUBOID      = 5'd0,
        SHP_SPHERE      = 5'd1,
        SHP_CYL_X       = 5'd2,
        SHP_CYL_Y       = 5'd3,
        SHP_CYL_Z       = 5'd4,
        SHP_WAVE_CYL2   = 5'd5,
        SHP_WAVE_CYL4   = 5'd6,
        SHP_SAW_CYL2    = 5'd7,
        SHP_SAW_CYL4    = 5'd8,
        SHP_WAVE_PRISM2 = 5'd9,
        SHP_WAVE_PRISM4 = 5'd10,
        SHP_SAW_PRISM2  = 5'd11,
        SHP_SAW_PRISM4  = 5'd12,
        SHP_SINE_WIND1  = 5'd13,
        SHP_SINE_WIND2  = 5'd14,
        SHP_TRI_WIND1   = 5'd15,
        SHP_TRI_WIND2   = 5'd16,
        SHP_SQR_WIND1   = 5'd17,
        SHP_SQR_WIND2   = 5'd18,
        SHP_NCUBE_X     = 5'd19,
        SHP_NCUBE_Y     = 5'd20,
        SHP_NCUBE_Z     = 5'd21,
        SHP_NCYL_X      = 5'd22,
        SHP_NCYL_Y      = 5'd23,
        SHP_NCYL_Z      = 5'd24,
        SHP_NPRISM_X    = 5'd25,
        SHP_NPRISM_Y    = 5'd26,
        SHP_NPRISM_Z    = 5'd27
    } shape_t;

    typedef struct packed {
        shape_t                     sel;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } in_beat_t;

    typedef struct packed {
        shape_t                     sel;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic [SQ_W-1:0]            sqx;
        logic [SQ_W-1:0]            sqy;
        logic [SQ_W-1:0]            sqz;
        logic [Q30_W-1:0]           depth;
        logic [Q30_W-1:0]           cos_mag;
        logic                       cos_neg;
        logic signed [CMP_W-1:0]    tri_off;
        logic                       sqr_hi;
        logic                       sqr_lo;
    } phase_beat_t;

    typedef struct packed {
        shape_t                     sel;
        logic signed [COORD_W-1:0]  y;
        logic [SUM_W-1:0]           s_all;
        logic [SUM_W-1:0]           s_pair;
        logic [SQ_W-1:0]            sq_a;
        logic [SQ_W-1:0]            sq_b;
        logic [PROD_W-1:0]          prod;
        logic signed [CMP_W-1:0]    upper;
        logic signed [CMP_W-1:0]    lower;
        logic                       prism_in;
    } prep_beat_t;

    // Quarter-wave cosine table, Q30, cos(pi/2*k/N) for k = 0..N.
    typedef logic [COS_TABLE_ENTRIES:0][Q30_W-1:0] cos_tab_t;

    // Unsigned long division by shift and subtract; used only to build the table.
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rm;
        q  = '0;
        rm = '0;
        for (int b = 63; b >= 0; b--) begin
            rm = {rm[63:0], num[b]};
            if (rm >= {1'b0, den}) begin
                rm   = rm - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [Q30_W-1:0] cos_entry(input int unsigned k);
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] dv;
        longint      acc;
        logic [Q30_W-1:0] r;
        th   = div_u64(K_HALFPI * 64'(k) + 64'(COS_TABLE_ENTRIES >> 1),
                       64'(COS_TABLE_ENTRIES));
        th2  = (th * th + (64'd1 << 29)) >> 30;
        term = 64'd1 << 30;
        acc  = longint'(64'd1 << 30);
        for (int unsigned i = 1; i <= 10; i++) begin
            dv   = 64'((2 * i - 1) * (2 * i));
            term = div_u64((term * th2 + (64'd1 << 29)) >> 30, dv);
            if ((i & 1) == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > longint'(64'd1 << 30))
            acc = longint'(64'd1 << 30);
        r = Q30_W'(acc);
        return r;
    endfunction

    function automatic cos_tab_t build_cos_tab();
        cos_tab_t t;
        for (int unsigned k = 0; k <= COS_TABLE_ENTRIES; k++)
            t[k] = cos_entry(k);
        return t;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

/* sv/point_in_shape_classifier_core.sv */
// Top level of the point-in-shape classifier: input register, shape register
// and the three-stage classification pipeline. Depends on pisc_pkg, pisc_phase,
// pisc_prep and pisc_decide.
//
//  Channel   Ports                                  Beat taken when
//  -------   ------------------------------------   -------------------------------
//  point     start, busy, coord_x/y/z               start && !busy
//  config    cfg_valid, cfg_ready, shape_select     cfg_valid && cfg_ready
//  result    done, inside_res                       done (one cycle, no backpressure)
//
// One point enters every clock; busy stays low and cfg_ready stays high.
// A point taken at an edge shows its result on inside_res with done high once it
// has passed the input register, phase/cosine table stage, depth multiplier stage
// and decision stage, in that order.
// Reset clears every valid flag and selects the cuboid shape (always inside).
// The receiver cannot stall, so nothing in the pipeline ever holds.
module point_in_shape_classifier_core
    import pisc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // point channel
    input  logic                       start,
    output logic                       busy,
    input  logic signed [COORD_W-1:0]  coord_x,
    input  logic signed [COORD_W-1:0]  coord_y,
    input  logic signed [COORD_W-1:0]  coord_z,
    // config channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [4:0]                 shape_select,
    // result channel
    output logic                       done,
    output logic                       inside_res
);

    // Shape register: written by a config beat, sampled into each point beat.
    shape_t      shape_reg;
    shape_t      shape_next;

    // Input register.
    logic        in_vld_reg;
    logic        in_vld_next;
    in_beat_t    in_beat_reg;
    in_beat_t    in_beat_next;

    // Stage-to-stage beats.
    logic        ph_valid;
    phase_beat_t ph_beat;
    logic        pr_valid;
    prep_beat_t  pr_beat;

    // No stall source anywhere: accept every cycle.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        shape_next = shape_reg;
        if (cfg_valid && cfg_ready)
            shape_next = shape_t'(shape_select);

        // Capture the point together with the shape it is to be tested against.
        in_vld_next      = start && !busy;
        in_beat_next.sel = shape_reg;
        in_beat_next.x   = coord_x;
        in_beat_next.y   = coord_y;
        in_beat_next.z   = coord_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg  <= SHP_CUBOID;
            in_vld_reg <= 1'b0;
        end
        else
        begin
            shape_reg  <= shape_next;
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_beat_reg <= in_beat_next;
    end

    // Stage 1: squares about the center, cosine lookup, triangle waves.
    pisc_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_vld_reg),
        .in_beat   (in_beat_reg),
        .out_valid (ph_valid),
        .out_beat  (ph_beat)
    );

    // Stage 2: depth product, sums of squares, winding edges, prism test.
    pisc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid),
        .in_beat   (ph_beat),
        .out_valid (pr_valid),
        .out_beat  (pr_beat)
    );

    // Stage 3: final compare per shape, drives the result strobe.
    pisc_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pr_valid),
        .in_beat   (pr_beat),
        .out_valid (done),
        .in_shape  (inside_res)
    );

    // Every accepted point comes out as a result strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted point produced no result");

    // No result without an earlier accepted point.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result strobe without an accepted point");

    // A config beat lands in the shape register at the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (shape_reg == shape_t'($past(shape_select))))
        else $error("shape register missed a config beat");

    // Without a config beat the shape register holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_valid |=> $stable(shape_reg))
        else $error("shape register changed without a config beat");

endmodule

/* sv/pisc_phase.sv */
// First stage: offset squares, phase rounding with cosine lookup, triangle waves.
// Depends on pisc_pkg.
module pisc_phase
    import pisc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  in_beat_t    in_beat,
    output logic        out_valid,
    output phase_beat_t out_beat
);

    localparam int unsigned F     = COORD_FRAC_BITS;
    localparam int unsigned TRI_W = F + 4;

    localparam logic signed [COORD_W:0]   HALF     = (COORD_W + 1)'(64'd1 << (F - 1));
    localparam logic [F-1:0]              QN_F     = F'(64'd1 << (F - 2));
    localparam logic [F-1:0]              QN3_F    = F'(64'd3 << (F - 2));
    localparam logic signed [TRI_W-1:0]   TWO_ONE  = TRI_W'(64'd1 << (F + 1));
    localparam logic signed [TRI_W-1:0]   FOUR_ONE = TRI_W'(64'd1 << (F + 2));

    function automatic logic [SQ_W-1:0] sq_off(input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        m;
        d = (COORD_W + 1)'(v) - HALF;
        m = d[COORD_W] ? (COORD_W + 1)'(-d) : (COORD_W + 1)'(d);
        return SQ_W'(m[COORD_W-1:0]) * SQ_W'(m[COORD_W-1:0]);
    endfunction

    function automatic logic signed [TRI_W-1:0] tri_wave(input logic [F-1:0] t);
        logic signed [TRI_W-1:0] t4;
        logic signed [TRI_W-1:0] r;
        t4 = signed'(TRI_W'({t, 2'b00}));
        if (t < QN_F)
            r = t4;
        else if (t < QN3_F)
            r = TWO_ONE - t4;
        else
            r = t4 - FOUR_ONE;
        return r;
    endfunction

    logic [F-1:0]             u1;
    logic [F-1:0]             u2;
    logic [F-1:0]             u;
    logic [F-1:0]             u_shift;
    logic [F-1:0]             u_hi;
    logic [F-1:0]             u_lo;
    logic [PHASE_W:0]         ph_sum;
    logic [1:0]               quad;
    logic [COS_IDX_W-1:0]     rem;
    logic [COS_IDX_W:0]       idx;
    logic [Q30_W-1:0]         cos_mag;
    logic signed [TRI_W-1:0]  tw;
    logic signed [TRI_W-1:0]  tw_neg;
    logic signed [TRI_W-1:0]  tw_wind;
    logic [F:0]               tri_mag;
    logic [Q30_W-1:0]         d_saw;
    logic                     waved;

    logic        valid_reg;
    logic        valid_next;
    phase_beat_t beat_reg;
    phase_beat_t beat_next;

    always_comb
    begin
        u1 = in_beat.x[F-1:0];
        u2 = {in_beat.x[F-2:0], 1'b0};
        u  = in_beat.sel[0] ? u1 : u2;

        // Round the phase to 4N steps per turn; the wrap comes from dropping the carry.
        ph_sum  = {1'b0, u[F-1:PHASE_SH]} + (PHASE_W + 1)'(u[PHASE_SH-1]);
        quad    = ph_sum[PHASE_W-1:PHASE_W-2];
        rem     = ph_sum[COS_IDX_W-1:0];
        idx     = quad[0] ? ((COS_IDX_W + 1)'(COS_TABLE_ENTRIES) - {1'b0, rem}) : {1'b0, rem};
        cos_mag = COS_TAB[idx];

        tw      = tri_wave(u);
        tw_neg  = -tw;
        tri_mag = tw[TRI_W-1] ? tw_neg[F:0] : tw[F:0];
        d_saw   = Q30_W'(tri_mag) << (30 - F);

        waved = (in_beat.sel == SHP_WAVE_CYL2)   || (in_beat.sel == SHP_WAVE_CYL4) ||
                (in_beat.sel == SHP_WAVE_PRISM2) || (in_beat.sel == SHP_WAVE_PRISM4);

        u_shift = u - QN_F;
        tw_wind = tri_wave(u_shift);
        u_hi    = u - K013_F;
        u_lo    = u - K037_F;

        beat_next.sel     = in_beat.sel;
        beat_next.x       = in_beat.x;
        beat_next.y       = in_beat.y;
        beat_next.z       = in_beat.z;
        beat_next.sqx     = sq_off(in_beat.x);
        beat_next.sqy     = sq_off(in_beat.y);
        beat_next.sqz     = sq_off(in_beat.z);
        beat_next.depth   = waved ? (Q30_ONE - cos_mag) : d_saw;
        beat_next.cos_mag = cos_mag;
        beat_next.cos_neg = quad[1] ^ quad[0];
        beat_next.tri_off = CMP_W'(tw_wind >>> 2);
        beat_next.sqr_hi  = u_hi < K074_F;
        beat_next.sqr_lo  = u_lo < K026_F;

        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

/* sv/pisc_prep.sv */
// Second stage: depth multiply, square sums, winding edges and prism test.
// Depends on pisc_pkg.
module pisc_prep
    import pisc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  phase_beat_t in_beat,
    output logic        out_valid,
    output prep_beat_t  out_beat
);

    logic [SQ_W-1:0]          sq_a;
    logic [SQ_W-1:0]          sq_b;
    logic [Q30_W:0]           off_sum;
    logic [Q30_W:0]           off_mag;
    logic signed [CMP_W-1:0]  off_pos;
    logic signed [CMP_W-1:0]  off;
    logic signed [CMP_W-1:0]  upper;
    logic signed [CMP_W-1:0]  lower;
    logic signed [CMP_W-1:0]  pa;
    logic signed [CMP_W-1:0]  pb;
    logic signed [CMP_W-1:0]  pa_m;

    logic        valid_reg;
    logic        valid_next;
    prep_beat_t  beat_reg;
    prep_beat_t  beat_next;

    always_comb
    begin
        case (in_beat.sel) inside
            SHP_CYL_Y, SHP_NCUBE_Y, SHP_NCYL_Y:
            begin
                sq_a = in_beat.sqx;
                sq_b = in_beat.sqz;
            end
            SHP_CYL_Z, SHP_NCUBE_Z, SHP_NCYL_Z:
            begin
                sq_a = in_beat.sqx;
                sq_b = in_beat.sqy;
            end
            SHP_WAVE_PRISM2, SHP_WAVE_PRISM4, SHP_SAW_PRISM2, SHP_SAW_PRISM4:
            begin
                sq_a = in_beat.sqy;
                sq_b = '0;
            end
            default:
            begin
                sq_a = in_beat.sqy;
                sq_b = in_beat.sqz;
            end
        endcase

        // Sine winding offset: -cos/4, rounded half up on the magnitude.
        off_sum = {1'b0, in_beat.cos_mag} + (Q30_W + 1)'(64'd1 << (SINE_SH - 1));
        off_mag = off_sum >> SINE_SH;
        off_pos = signed'(CMP_W'(off_mag));
        off     = in_beat.cos_neg ? off_pos : -off_pos;

        case (in_beat.sel) inside
            SHP_SINE_WIND1, SHP_SINE_WIND2:
            begin
                upper = off + QN3_C;
                lower = off + QN_C;
            end
            SHP_TRI_WIND1, SHP_TRI_WIND2:
            begin
                upper = in_beat.tri_off + QN3_C;
                lower = in_beat.tri_off + QN_C;
            end
            SHP_SQR_WIND1, SHP_SQR_WIND2:
            begin
                upper = in_beat.sqr_hi ? ONE_C : HALF_C;
                lower = in_beat.sqr_lo ? HALF_C : '0;
            end
            default:
            begin
                upper = '0;
                lower = '0;
            end
        endcase

        case (in_beat.sel)
            SHP_NPRISM_X:
            begin
                pa = CMP_W'(in_beat.z);
                pb = CMP_W'(in_beat.y);
            end
            SHP_NPRISM_Y:
            begin
                pa = CMP_W'(in_beat.z);
                pb = CMP_W'(in_beat.x);
            end
            default:
            begin
                pa = CMP_W'(in_beat.x);
                pb = CMP_W'(in_beat.y);
            end
        endcase
        pa_m = pa - C03_C;

        beat_next.sel      = in_beat.sel;
        beat_next.y        = in_beat.y;
        beat_next.s_all    = SUM_W'(in_beat.sqx) + SUM_W'(in_beat.sqy) + SUM_W'(in_beat.sqz);
        beat_next.s_pair   = SUM_W'(sq_a) + SUM_W'(sq_b);
        beat_next.sq_a     = sq_a;
        beat_next.sq_b     = sq_b;
        beat_next.prod     = PROD_W'(in_beat.depth) * PROD_W'(K009);
        beat_next.upper    = upper;
        beat_next.lower    = lower;
        beat_next.prism_in = !((pa_m > pb) || (pa_m > (ONE_C - pb)) || (pa < C03_C));

        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

/* sv/pisc_decide.sv */
// Last stage: round the waved or sawed depth and pick the test for the shape.
// Depends on pisc_pkg.
module pisc_decide
    import pisc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  prep_beat_t  in_beat,
    output logic        out_valid,
    output logic        in_shape
);

    logic [PROD_W-1:0]           dep_sum;
    logic [PROD_W-DEPTH_SH-1:0]  dep;
    logic [SUM_W-1:0]            lhs_wave;
    logic signed [CMP_W-1:0]     y_c;
    logic                        inside_next;
    logic                        inside_reg;
    logic                        valid_next;
    logic                        valid_reg;

    always_comb
    begin
        dep_sum  = in_beat.prod + PROD_W'(64'd1 << (DEPTH_SH - 1));
        dep      = dep_sum[PROD_W-1:DEPTH_SH];
        lhs_wave = in_beat.s_pair + SUM_W'(dep);
        y_c      = CMP_W'(in_beat.y);

        case (in_beat.sel) inside
            SHP_SPHERE:
                inside_next = in_beat.s_all <= QW;
            SHP_CYL_X, SHP_CYL_Y, SHP_CYL_Z:
                inside_next = in_beat.s_pair <= QW;
            SHP_WAVE_CYL2, SHP_WAVE_CYL4, SHP_SAW_CYL2, SHP_SAW_CYL4,
            SHP_WAVE_PRISM2, SHP_WAVE_PRISM4, SHP_SAW_PRISM2, SHP_SAW_PRISM4:
                inside_next = lhs_wave <= QW;
            SHP_SINE_WIND1, SHP_SINE_WIND2, SHP_TRI_WIND1, SHP_TRI_WIND2,
            SHP_SQR_WIND1, SHP_SQR_WIND2:
                inside_next = !((y_c > in_beat.upper) || (y_c < in_beat.lower));
            SHP_NCUBE_X, SHP_NCUBE_Y, SHP_NCUBE_Z:
                inside_next = !((SUM_W'(in_beat.sq_a) > SW) || (SUM_W'(in_beat.sq_b) > SW));
            SHP_NCYL_X, SHP_NCYL_Y, SHP_NCYL_Z:
                inside_next = in_beat.s_pair <= QPI_2F;
            SHP_NPRISM_X, SHP_NPRISM_Y, SHP_NPRISM_Z:
                inside_next = in_beat.prism_in;
            default:
                inside_next = 1'b1;
        endcase

        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        inside_reg <= inside_next;
    end

    assign out_valid = valid_reg;
    assign in_shape  = inside_reg;

endmodule
